// ===== rtl/tekd_pkg.sv =====
// Package: state type, byte constants and key codes for the escape key decoder.
`timescale 1ns / 1ps
`default_nettype none

package tekd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_SS3  = 2'd2,
        PH_CSI  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SEMI_NONE  = 2'd0,
        SEMI_SEEN  = 2'd1,
        SEMI_AFTER = 2'd2
    } t_semi;

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_O     = 8'h4F;
    localparam logic [7:0] BYTE_P     = 8'h50;
    localparam logic [7:0] BYTE_LBR   = 8'h5B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_0     = 8'h30;
    localparam logic [7:0] BYTE_1     = 8'h31;
    localparam logic [7:0] BYTE_2     = 8'h32;
    localparam logic [7:0] BYTE_3     = 8'h33;
    localparam logic [7:0] BYTE_4     = 8'h34;
    localparam logic [7:0] BYTE_5     = 8'h35;
    localparam logic [7:0] BYTE_6     = 8'h36;
    localparam logic [7:0] BYTE_7     = 8'h37;
    localparam logic [7:0] BYTE_8     = 8'h38;
    localparam logic [7:0] BYTE_9     = 8'h39;
    localparam logic [7:0] BYTE_A     = 8'h41;
    localparam logic [7:0] BYTE_B     = 8'h42;
    localparam logic [7:0] BYTE_C     = 8'h43;
    localparam logic [7:0] BYTE_D     = 8'h44;
    localparam logic [7:0] BYTE_F     = 8'h46;
    localparam logic [7:0] BYTE_H     = 8'h48;
    localparam logic [7:0] BYTE_Z     = 8'h5A;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;

    localparam logic [7:0] KEY_NONE        = 8'h00;
    localparam logic [7:0] KEY_LEFT        = 8'hB4;
    localparam logic [7:0] KEY_UP          = 8'hB5;
    localparam logic [7:0] KEY_DOWN        = 8'hB6;
    localparam logic [7:0] KEY_RIGHT       = 8'hB7;
    localparam logic [7:0] KEY_SHIFT_LEFT  = 8'hB8;
    localparam logic [7:0] KEY_SHIFT_UP    = 8'hB9;
    localparam logic [7:0] KEY_SHIFT_DOWN  = 8'hBA;
    localparam logic [7:0] KEY_SHIFT_RIGHT = 8'hBB;
    localparam logic [7:0] KEY_CTRL_LEFT   = 8'hBC;
    localparam logic [7:0] KEY_CTRL_RIGHT  = 8'hBD;
    localparam logic [7:0] KEY_F1          = 8'hC1;
    localparam logic [7:0] KEY_BACK_TAB    = 8'hC2;
    localparam logic [7:0] KEY_HOME        = 8'hD2;
    localparam logic [7:0] KEY_DELETE      = 8'hD4;
    localparam logic [7:0] KEY_END         = 8'hD5;
    localparam logic [7:0] KEY_PAGE_UP     = 8'hD6;
    localparam logic [7:0] KEY_PAGE_DOWN   = 8'hD7;
    localparam logic [7:0] KEY_SHIFT_HOME  = 8'hD8;
    localparam logic [7:0] KEY_SHIFT_END   = 8'hD9;
    localparam logic [7:0] KEY_CTRL_HOME   = 8'hDA;
    localparam logic [7:0] KEY_CTRL_END    = 8'hDB;

    function automatic logic [7:0] pick_mod(input logic [7:0] plain,
                                            input logic [7:0] shifted,
                                            input logic [7:0] ctrled,
                                            input logic shift_flag,
                                            input logic ctrl_flag);
        logic [7:0] key;
        if (ctrl_flag) begin
            key = ctrled;
        end else if (shift_flag) begin
            key = shifted;
        end else begin
            key = plain;
        end
        return key;
    endfunction

    function automatic logic [7:0] decode_final(input logic [7:0] fin,
                                                input logic [7:0] p0,
                                                input logic [7:0] p1,
                                                input logic shift_flag,
                                                input logic ctrl_flag);
        logic       shift_only;
        logic [7:0] key;
        shift_only = shift_flag & ~ctrl_flag;
        case (fin)
            BYTE_A: key = shift_only ? KEY_SHIFT_UP : KEY_UP;
            BYTE_B: key = shift_only ? KEY_SHIFT_DOWN : KEY_DOWN;
            BYTE_C: key = pick_mod(KEY_RIGHT, KEY_SHIFT_RIGHT, KEY_CTRL_RIGHT,
                                   shift_flag, ctrl_flag);
            BYTE_D: key = pick_mod(KEY_LEFT, KEY_SHIFT_LEFT, KEY_CTRL_LEFT,
                                   shift_flag, ctrl_flag);
            BYTE_H: key = pick_mod(KEY_HOME, KEY_SHIFT_HOME, KEY_CTRL_HOME,
                                   shift_flag, ctrl_flag);
            BYTE_F: key = pick_mod(KEY_END, KEY_SHIFT_END, KEY_CTRL_END,
                                   shift_flag, ctrl_flag);
            BYTE_Z: key = KEY_BACK_TAB;
            BYTE_TILDE: begin
                if (p0 == BYTE_1 && p1 == BYTE_1) begin
                    key = KEY_F1;
                end else if (p0 == BYTE_3) begin
                    key = KEY_DELETE;
                end else if (p0 == BYTE_5) begin
                    key = KEY_PAGE_UP;
                end else if (p0 == BYTE_6) begin
                    key = KEY_PAGE_DOWN;
                end else if (p0 == BYTE_1 || p0 == BYTE_7) begin
                    key = pick_mod(KEY_HOME, KEY_SHIFT_HOME, KEY_CTRL_HOME,
                                   shift_flag, ctrl_flag);
                end else if (p0 == BYTE_4 || p0 == BYTE_8) begin
                    key = pick_mod(KEY_END, KEY_SHIFT_END, KEY_CTRL_END,
                                   shift_flag, ctrl_flag);
                end else begin
                    key = KEY_NONE;
                end
            end
            default: key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/terminal_escape_key_decoder.sv =====
// Top level: terminal escape sequence key decoder with input and result registers.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------
//  s       | in  | i_s_tvalid / o_s_tready | i_s_tdata[7:0] rx_byte
//  m       | out | o_m_tvalid / i_m_tready | o_m_tdata[7:0] key_code
//
//  One byte per cycle unless m stalls; a taken byte sits in the input register until it
//  advances through the single decode stage between the input and result registers.
//  Bytes that only continue a sequence leave no result.
//  Reset is synchronous, active low, and returns the decoder to idle.
//  A stall on m holds the result; s keeps taking bytes until the input register fills.
`timescale 1ns / 1ps
`default_nettype none

module terminal_escape_key_decoder #(
    parameter int PARAM_MAX = 7
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [7:0] key_code
);

    localparam int CW = $clog2(PARAM_MAX + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(PARAM_MAX);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    logic [7:0]        r_out_key;

    tekd_pkg::t_phase  r_phase, n_phase;
    logic [CW-1:0]     r_param_count, n_param_count;
    logic [7:0]        r_p0, n_p0;
    logic [7:0]        r_p1, n_p1;
    tekd_pkg::t_semi   r_semi, n_semi;
    logic              r_shift, n_shift;
    logic              r_ctrl, n_ctrl;
    logic              n_emit;
    logic [7:0]        n_key;

    logic              advance;
    logic              s_fire;
    logic              is_param;

    assign advance    = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_in_valid | advance;
    assign s_fire     = i_s_tvalid & o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_key;

    assign is_param = (r_in_byte >= tekd_pkg::BYTE_0 && r_in_byte <= tekd_pkg::BYTE_9)
                      || r_in_byte == tekd_pkg::BYTE_SEMI;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (s_fire) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            r_out_key <= n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= tekd_pkg::PH_IDLE;
            r_param_count <= '0;
            r_p0          <= '0;
            r_p1          <= '0;
            r_semi        <= tekd_pkg::SEMI_NONE;
            r_shift       <= 1'b0;
            r_ctrl        <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_param_count <= n_param_count;
            r_p0          <= n_p0;
            r_p1          <= n_p1;
            r_semi        <= n_semi;
            r_shift       <= n_shift;
            r_ctrl        <= n_ctrl;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_param_count = r_param_count;
        n_p0          = r_p0;
        n_p1          = r_p1;
        n_semi        = r_semi;
        n_shift       = r_shift;
        n_ctrl        = r_ctrl;
        n_emit        = 1'b0;
        n_key         = tekd_pkg::KEY_NONE;
        case (r_phase)
            tekd_pkg::PH_IDLE: begin
                if (r_in_byte == tekd_pkg::BYTE_ESC) begin
                    n_phase = tekd_pkg::PH_ESC;
                end else begin
                    n_emit = 1'b1;
                    n_key  = r_in_byte;
                end
            end
            tekd_pkg::PH_ESC: begin
                if (r_in_byte == tekd_pkg::BYTE_O) begin
                    n_phase = tekd_pkg::PH_SS3;
                end else if (r_in_byte == tekd_pkg::BYTE_LBR) begin
                    n_phase       = tekd_pkg::PH_CSI;
                    n_param_count = '0;
                    n_p0          = '0;
                    n_p1          = '0;
                    n_semi        = tekd_pkg::SEMI_NONE;
                    n_shift       = 1'b0;
                    n_ctrl        = 1'b0;
                end else begin
                    n_phase = tekd_pkg::PH_IDLE;
                    n_emit  = 1'b1;
                end
            end
            tekd_pkg::PH_SS3: begin
                n_phase = tekd_pkg::PH_IDLE;
                n_emit  = 1'b1;
                n_key   = (r_in_byte == tekd_pkg::BYTE_P) ? tekd_pkg::KEY_F1
                                                          : tekd_pkg::KEY_NONE;
            end
            tekd_pkg::PH_CSI: begin
                if (is_param) begin
                    // drop parameter characters past the limit
                    if (r_param_count < CNT_MAX) begin
                        if (r_param_count == '0) begin
                            n_p0 = r_in_byte;
                        end else if (r_param_count == CW'(1)) begin
                            n_p1 = r_in_byte;
                        end
                        n_param_count = r_param_count + CW'(1);
                        if (r_semi == tekd_pkg::SEMI_NONE) begin
                            if (r_in_byte == tekd_pkg::BYTE_SEMI) begin
                                n_semi = tekd_pkg::SEMI_SEEN;
                            end
                        end else if (r_semi == tekd_pkg::SEMI_SEEN) begin
                            if (r_in_byte == tekd_pkg::BYTE_2) begin
                                n_shift = 1'b1;
                            end
                            if (r_in_byte == tekd_pkg::BYTE_5) begin
                                n_ctrl = 1'b1;
                            end
                            n_semi = tekd_pkg::SEMI_AFTER;
                        end
                    end
                end else begin
                    n_phase = tekd_pkg::PH_IDLE;
                    n_emit  = 1'b1;
                    n_key   = tekd_pkg::decode_final(r_in_byte, r_p0, r_p1,
                                                     r_shift, r_ctrl);
                end
            end
            default: begin
                n_phase = tekd_pkg::PH_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_param_count <= CNT_MAX)
        else $error("parameter count beyond limit");

    a_mod_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_shift && r_ctrl))
        else $error("shift and ctrl both set");

    a_esc_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_phase == tekd_pkg::PH_IDLE && r_in_byte == tekd_pkg::BYTE_ESC)
        |=> (r_phase == tekd_pkg::PH_ESC && !$rose(r_out_valid)))
        else $error("escape did not open a sequence");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(advance))
        else $error("result without a decoded request");

    a_sequence_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_emit) |=> r_phase == tekd_pkg::PH_IDLE)
        else $error("result given without returning to idle");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the terminal escape key decoder: byte stream in, decoded keys checked in order.
`timescale 1ns / 1ps

module tb;

    localparam int PARAM_MAX   = 7;
    localparam int HALF_PERIOD = 6;
    localparam int CALM_TAIL   = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 90;
    localparam int PAUSE_AT    = 800;
    localparam int RANDOM_BYTES = 1200;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;

    logic [7:0] rx_pending[$];
    logic [7:0] key_expected[$];
    int         mismatches = 0;
    int         rx_taken   = 0;
    logic       s_fired    = 1'b0;

    int send_gap   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    bit pause_done = 1'b0;

    tekd_pkg::t_phase dec_phase = tekd_pkg::PH_IDLE;
    int               dec_count = 0;
    logic [7:0]       dec_p0    = 8'h00;
    logic [7:0]       dec_p1    = 8'h00;
    tekd_pkg::t_semi  dec_semi  = tekd_pkg::SEMI_NONE;
    logic             dec_shift = 1'b0;
    logic             dec_ctrl  = 1'b0;

    terminal_escape_key_decoder #(
        .PARAM_MAX(PARAM_MAX)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),    // [7:0] rx_byte
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata)   // [7:0] key_code
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic logic [7:0] modified_key(input logic [7:0] plain,
                                                input logic [7:0] shifted,
                                                input logic [7:0] ctrled);
        if (dec_ctrl) begin
            return ctrled;
        end
        if (dec_shift) begin
            return shifted;
        end
        return plain;
    endfunction

    function automatic logic [7:0] final_key(input logic [7:0] fin);
        logic [7:0] key;
        key = tekd_pkg::KEY_NONE;
        case (fin)
            tekd_pkg::BYTE_A: key = (dec_shift && !dec_ctrl) ? tekd_pkg::KEY_SHIFT_UP
                                                             : tekd_pkg::KEY_UP;
            tekd_pkg::BYTE_B: key = (dec_shift && !dec_ctrl) ? tekd_pkg::KEY_SHIFT_DOWN
                                                             : tekd_pkg::KEY_DOWN;
            tekd_pkg::BYTE_C: key = modified_key(tekd_pkg::KEY_RIGHT, tekd_pkg::KEY_SHIFT_RIGHT,
                                                 tekd_pkg::KEY_CTRL_RIGHT);
            tekd_pkg::BYTE_D: key = modified_key(tekd_pkg::KEY_LEFT, tekd_pkg::KEY_SHIFT_LEFT,
                                                 tekd_pkg::KEY_CTRL_LEFT);
            tekd_pkg::BYTE_H: key = modified_key(tekd_pkg::KEY_HOME, tekd_pkg::KEY_SHIFT_HOME,
                                                 tekd_pkg::KEY_CTRL_HOME);
            tekd_pkg::BYTE_F: key = modified_key(tekd_pkg::KEY_END, tekd_pkg::KEY_SHIFT_END,
                                                 tekd_pkg::KEY_CTRL_END);
            tekd_pkg::BYTE_Z: key = tekd_pkg::KEY_BACK_TAB;
            tekd_pkg::BYTE_TILDE: begin
                if (dec_p0 == tekd_pkg::BYTE_1 && dec_p1 == tekd_pkg::BYTE_1) begin
                    key = tekd_pkg::KEY_F1;
                end else if (dec_p0 == tekd_pkg::BYTE_3) begin
                    key = tekd_pkg::KEY_DELETE;
                end else if (dec_p0 == tekd_pkg::BYTE_5) begin
                    key = tekd_pkg::KEY_PAGE_UP;
                end else if (dec_p0 == tekd_pkg::BYTE_6) begin
                    key = tekd_pkg::KEY_PAGE_DOWN;
                end else if (dec_p0 == tekd_pkg::BYTE_1 || dec_p0 == tekd_pkg::BYTE_7) begin
                    key = modified_key(tekd_pkg::KEY_HOME, tekd_pkg::KEY_SHIFT_HOME,
                                       tekd_pkg::KEY_CTRL_HOME);
                end else if (dec_p0 == tekd_pkg::BYTE_4 || dec_p0 == tekd_pkg::BYTE_8) begin
                    key = modified_key(tekd_pkg::KEY_END, tekd_pkg::KEY_SHIFT_END,
                                       tekd_pkg::KEY_CTRL_END);
                end
            end
            default: key = tekd_pkg::KEY_NONE;
        endcase
        return key;
    endfunction

    // advance the decoder state by one byte; returns 1 when a key comes out
    function automatic bit decode_rx(input logic [7:0] rx, output logic [7:0] key);
        key = tekd_pkg::KEY_NONE;
        case (dec_phase)
            tekd_pkg::PH_IDLE: begin
                if (rx == tekd_pkg::BYTE_ESC) begin
                    dec_phase = tekd_pkg::PH_ESC;
                    return 1'b0;
                end
                key = rx;
                return 1'b1;
            end
            tekd_pkg::PH_ESC: begin
                if (rx == tekd_pkg::BYTE_O) begin
                    dec_phase = tekd_pkg::PH_SS3;
                    return 1'b0;
                end
                if (rx == tekd_pkg::BYTE_LBR) begin
                    dec_phase = tekd_pkg::PH_CSI;
                    dec_count = 0;
                    dec_p0    = 8'h00;
                    dec_p1    = 8'h00;
                    dec_semi  = tekd_pkg::SEMI_NONE;
                    dec_shift = 1'b0;
                    dec_ctrl  = 1'b0;
                    return 1'b0;
                end
                dec_phase = tekd_pkg::PH_IDLE;
                return 1'b1;
            end
            tekd_pkg::PH_SS3: begin
                dec_phase = tekd_pkg::PH_IDLE;
                key = (rx == tekd_pkg::BYTE_P) ? tekd_pkg::KEY_F1 : tekd_pkg::KEY_NONE;
                return 1'b1;
            end
            default: begin
                if ((rx >= tekd_pkg::BYTE_0 && rx <= tekd_pkg::BYTE_9)
                    || rx == tekd_pkg::BYTE_SEMI) begin
                    if (dec_count < PARAM_MAX) begin
                        if (dec_count == 0) begin
                            dec_p0 = rx;
                        end else if (dec_count == 1) begin
                            dec_p1 = rx;
                        end
                        dec_count++;
                        if (dec_semi == tekd_pkg::SEMI_NONE) begin
                            if (rx == tekd_pkg::BYTE_SEMI) begin
                                dec_semi = tekd_pkg::SEMI_SEEN;
                            end
                        end else if (dec_semi == tekd_pkg::SEMI_SEEN) begin
                            if (rx == tekd_pkg::BYTE_2) begin
                                dec_shift = 1'b1;
                            end
                            if (rx == tekd_pkg::BYTE_5) begin
                                dec_ctrl = 1'b1;
                            end
                            dec_semi = tekd_pkg::SEMI_AFTER;
                        end
                    end
                    return 1'b0;
                end
                key = final_key(rx);
                dec_phase = tekd_pkg::PH_IDLE;
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [7:0] key;
        logic [7:0] want;
        s_fired <= i_rst_n && s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && m_tready) begin
                if (key_expected.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected key_code %02h with nothing pending", o_m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = key_expected.pop_front();
                    if (o_m_tdata !== want) begin
                        if (mismatches < 10) begin
                            $display("key_code: expected %02h, got %02h", want, o_m_tdata);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && o_s_tready) begin
                rx_taken++;
                if (decode_rx(s_tdata, key)) begin
                    key_expected.push_back(key);
                end
            end
        end
    end

    always @(negedge i_clk) begin : driver
        logic       nv;
        logic [7:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (i_rst_n && (!s_tvalid || s_fired)) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (rx_taken >= PAUSE_AT && !pause_done) begin
                // hold until every pending key has come out
                if (key_expected.size() == 0) begin
                    pause_done = 1'b1;
                end
            end else if (rx_pending.size() != 0) begin
                nv = 1'b1;
                nd = rx_pending.pop_front();
                if (rx_pending.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 11);
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
    end

    always @(negedge i_clk) begin : receiver
        logic nr;
        nr = 1'b1;
        if (!hold_done && rx_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else if (rx_pending.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            nr = 1'b0;
        end
        m_tready <= nr;
    end

    initial begin
        #6_000_000;
        $display("terminal_escape_key_decoder: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] leads[8];
        logic [7:0] finals[8];
        int         pick;
        int         n;
        leads  = '{tekd_pkg::BYTE_1, tekd_pkg::BYTE_3, tekd_pkg::BYTE_4, tekd_pkg::BYTE_5,
                   tekd_pkg::BYTE_6, tekd_pkg::BYTE_7, tekd_pkg::BYTE_8, tekd_pkg::BYTE_1};
        finals = '{tekd_pkg::BYTE_A, tekd_pkg::BYTE_B, tekd_pkg::BYTE_C, tekd_pkg::BYTE_D,
                   tekd_pkg::BYTE_H, tekd_pkg::BYTE_F, tekd_pkg::BYTE_Z, tekd_pkg::BYTE_TILDE};

        // extremes, SS3 F1, ESC as introducer, modifier, "11~", double semicolon, ESC as final
        rx_pending = '{8'h00, 8'hFF,
                       tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_O, tekd_pkg::BYTE_P,
                       tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_ESC,
                       tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_LBR, tekd_pkg::BYTE_1,
                       tekd_pkg::BYTE_SEMI, tekd_pkg::BYTE_2, tekd_pkg::BYTE_C,
                       tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_LBR, tekd_pkg::BYTE_1,
                       tekd_pkg::BYTE_1, tekd_pkg::BYTE_TILDE,
                       tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_LBR, tekd_pkg::BYTE_SEMI,
                       tekd_pkg::BYTE_SEMI, tekd_pkg::BYTE_2, tekd_pkg::BYTE_D,
                       tekd_pkg::BYTE_ESC, tekd_pkg::BYTE_LBR, tekd_pkg::BYTE_ESC};

        while (rx_pending.size() < RANDOM_BYTES + 27) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                rx_pending.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 40) begin
                rx_pending.push_back(tekd_pkg::BYTE_ESC);
                rx_pending.push_back(tekd_pkg::BYTE_O);
                rx_pending.push_back($urandom_range(0, 1) ? tekd_pkg::BYTE_P
                                     : 8'($urandom_range(0, 255)));
            end else if (pick < 45) begin
                rx_pending.push_back(tekd_pkg::BYTE_ESC);
                rx_pending.push_back(8'($urandom_range(0, 255)));
            end else begin
                rx_pending.push_back(tekd_pkg::BYTE_ESC);
                rx_pending.push_back(tekd_pkg::BYTE_LBR);
                if ($urandom_range(0, 3) == 0) begin
                    // loose parameter string, long enough at times to overflow
                    n = $urandom_range(0, 11);
                    repeat (n) begin
                        rx_pending.push_back(($urandom_range(0, 4) == 0) ? tekd_pkg::BYTE_SEMI
                                             : 8'(tekd_pkg::BYTE_0 + $urandom_range(0, 9)));
                    end
                end else begin
                    if ($urandom_range(0, 4) != 0) begin
                        rx_pending.push_back(($urandom_range(0, 5) == 0)
                                             ? 8'(tekd_pkg::BYTE_0 + $urandom_range(0, 9))
                                             : leads[$urandom_range(0, 7)]);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        rx_pending.push_back($urandom_range(0, 1) ? tekd_pkg::BYTE_1
                                             : 8'(tekd_pkg::BYTE_0 + $urandom_range(0, 9)));
                    end
                    if ($urandom_range(0, 1)) begin
                        rx_pending.push_back(tekd_pkg::BYTE_SEMI);
                        n = $urandom_range(0, 5);
                        if (n < 2) begin
                            rx_pending.push_back(tekd_pkg::BYTE_2);
                        end else if (n < 4) begin
                            rx_pending.push_back(tekd_pkg::BYTE_5);
                        end else if (n == 4) begin
                            rx_pending.push_back($urandom_range(0, 2) == 0
                                                 ? tekd_pkg::BYTE_SEMI
                                                 : 8'(tekd_pkg::BYTE_0
                                                      + $urandom_range(0, 9)));
                        end
                    end
                end
                n = $urandom_range(0, 9);
                if (n < 8) begin
                    rx_pending.push_back(finals[$urandom_range(0, 7)]);
                end else if (n == 8) begin
                    rx_pending.push_back(8'($urandom_range(0, 255)));
                end else begin
                    rx_pending.push_back(tekd_pkg::BYTE_ESC);
                end
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || s_tvalid) begin
            @(posedge i_clk);
        end
        while (key_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("terminal_escape_key_decoder: match");
        end else begin
            $display("terminal_escape_key_decoder: mismatch");
        end
        $finish;
    end

endmodule
